@@ rtl/msh_pkg.sv @@
// Package for the MFM sector header decoder: word types, kinds, MFM constants.
// Used by every module of the block; no dependencies.
package msh_pkg;

    // Default number of label longwords in a sector header
    localparam int unsigned LABEL_WORDS_DEF = 4;

    // Clock bits are dropped, data bits kept
    localparam logic [31:0] MFM_MASK = 32'h5555_5555;

    // Result kind codes
    typedef enum logic [1:0] {
        KIND_INFO      = 2'd0,
        KIND_LABEL     = 2'd1,
        KIND_HDR_CSUM  = 2'd2,
        KIND_DATA_CSUM = 2'd3
    } kind_t;

    // Input word: one raw longword from the track
    typedef struct packed {
        logic [31:0] raw_word;
        logic        sector_start;
    } in_t;

    // Result word
    typedef struct packed {
        kind_t       kind;
        logic [31:0] merged_value;
        logic [7:0]  format_byte;
        logic [6:0]  cylinder;
        logic        head;
        logic [7:0]  sector_id;
        logic [7:0]  sectors_to_gap;
        logic [1:0]  label_index;
        logic        header_ok;
    } out_t;

    // Merge an odd/even pair of MFM halves into one longword
    function automatic logic [31:0] merge_halves(input logic [31:0] odd,
                                                 input logic [31:0] even);
        merge_halves = ((odd & MFM_MASK) << 1) | (even & MFM_MASK);
    endfunction

endpackage

@@ rtl/msh_in_stage.sv @@
// Input register of the sector header decoder.
// Depends on msh_pkg for the input word type.
module msh_in_stage (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         item_valid,
    output logic         item_stall,
    input  msh_pkg::in_t item,
    input  logic         advance,
    output logic         held_valid,
    output msh_pkg::in_t held
);
    import msh_pkg::*;

    logic valid_reg;
    logic valid_next;
    in_t  word_reg;
    logic accept;

    // Stall only while a held word cannot move on
    assign item_stall = valid_reg && !advance;
    assign accept     = item_valid && !item_stall;

    always_comb
    begin
        if (accept)
            valid_next = 1'b1;
        else if (advance)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
            word_reg <= item;
    end

    assign held_valid = valid_reg;
    assign held       = word_reg;

endmodule

@@ rtl/msh_decode.sv @@
// Sector position tracking, odd-half and label storage, checksum and merge logic.
// Depends on msh_pkg for word types, kind codes and the merge function.
module msh_decode #(
    parameter int unsigned LABEL_WORDS = msh_pkg::LABEL_WORDS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          fire,
    input  msh_pkg::in_t  word,
    output logic          res_valid,
    output msh_pkg::out_t res
);
    import msh_pkg::*;

    localparam int unsigned POS_LABEL_ODD  = 2;
    localparam int unsigned POS_LABEL_EVEN = 2 + LABEL_WORDS;
    localparam int unsigned POS_HDR        = 2 + 2 * LABEL_WORDS;
    localparam int unsigned POS_DATA       = POS_HDR + 2;
    localparam int unsigned POS_IDLE       = POS_DATA + 2;
    localparam int unsigned POS_W          = $clog2(POS_IDLE + 1);
    localparam int unsigned IDX_W          = (LABEL_WORDS > 1) ? $clog2(LABEL_WORDS) : 1;

    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic [31:0]      odd_reg;
    logic [31:0]      odd_next;
    logic [31:0]      xor_reg;
    logic [31:0]      xor_next;
    logic [31:0]      label_mem [LABEL_WORDS];

    logic [POS_W-1:0] pos_eff;
    logic [POS_W-1:0] rel_odd;
    logic [POS_W-1:0] rel_even;
    logic [31:0]      xor_base;
    logic             active;
    logic             at_info_odd;
    logic             at_info_even;
    logic             at_lab_odd;
    logic             at_lab_even;
    logic             at_hdr_odd;
    logic             at_hdr_even;
    logic             at_data_odd;
    logic             at_data_even;
    logic [IDX_W-1:0] wr_idx;
    logic [IDX_W-1:0] rd_idx;
    logic [IDX_W+1:0] rd_idx_ext;
    logic [31:0]      merged_odd;
    logic [31:0]      merged_lab;

    // A sector start restarts at the odd info word with a fresh checksum
    assign pos_eff  = word.sector_start ? '0 : pos_reg;
    assign xor_base = word.sector_start ? '0 : xor_reg;
    assign active   = pos_eff < POS_W'(POS_IDLE);

    // Position decode
    assign at_info_odd  = pos_eff == '0;
    assign at_info_even = pos_eff == POS_W'(1);
    assign at_lab_odd   = (pos_eff >= POS_W'(POS_LABEL_ODD)) &&
                          (pos_eff <  POS_W'(POS_LABEL_EVEN));
    assign at_lab_even  = (pos_eff >= POS_W'(POS_LABEL_EVEN)) &&
                          (pos_eff <  POS_W'(POS_HDR));
    assign at_hdr_odd   = pos_eff == POS_W'(POS_HDR);
    assign at_hdr_even  = pos_eff == POS_W'(POS_HDR + 1);
    assign at_data_odd  = pos_eff == POS_W'(POS_DATA);
    assign at_data_even = pos_eff == POS_W'(POS_DATA + 1);

    assign rel_odd    = pos_eff - POS_W'(POS_LABEL_ODD);
    assign rel_even   = pos_eff - POS_W'(POS_LABEL_EVEN);
    assign wr_idx     = rel_odd[IDX_W-1:0];
    assign rd_idx     = rel_even[IDX_W-1:0];
    assign rd_idx_ext = {2'b00, rd_idx};

    assign merged_odd = merge_halves(odd_reg, word.raw_word);
    assign merged_lab = merge_halves(label_mem[rd_idx], word.raw_word);

    // Next state
    always_comb
    begin
        pos_next = pos_reg;
        odd_next = odd_reg;
        xor_next = xor_reg;
        if (fire)
        begin
            if (active)
            begin
                pos_next = pos_eff + POS_W'(1);
                xor_next = (pos_eff < POS_W'(POS_HDR)) ? (xor_base ^ word.raw_word)
                                                       : xor_base;
                if (at_info_odd || at_hdr_odd || at_data_odd)
                    odd_next = word.raw_word;
            end
            else
            begin
                pos_next = POS_W'(POS_IDLE);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= POS_W'(POS_IDLE);
            odd_reg <= '0;
            xor_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
            odd_reg <= odd_next;
            xor_reg <= xor_next;
        end
    end

    // Odd label halves, written before their even partner is read
    always_ff @(posedge clk)
    begin
        if (fire && at_lab_odd)
            label_mem[wr_idx] <= word.raw_word;
    end

    // Result word
    always_comb
    begin
        res       = '0;
        res.kind  = KIND_INFO;
        res_valid = active && (at_info_even || at_lab_even || at_hdr_even || at_data_even);
        if (at_info_even)
        begin
            res.kind           = KIND_INFO;
            res.merged_value   = merged_odd;
            res.format_byte    = merged_odd[31:24];
            res.cylinder       = merged_odd[23:17];
            res.head           = merged_odd[16];
            res.sector_id      = merged_odd[15:8];
            res.sectors_to_gap = merged_odd[7:0];
        end
        else if (at_lab_even)
        begin
            res.kind         = KIND_LABEL;
            res.merged_value = merged_lab;
            res.label_index  = rd_idx_ext[1:0];
        end
        else if (at_hdr_even)
        begin
            res.kind         = KIND_HDR_CSUM;
            res.merged_value = merged_odd;
            res.header_ok    = (xor_base & MFM_MASK) == merged_odd;
        end
        else if (at_data_even)
        begin
            res.kind         = KIND_DATA_CSUM;
            res.merged_value = merged_odd;
        end
    end

    // A sector start always lands on the even info position next
    a_start_pos: assert property (@(posedge clk) disable iff (!rst_n)
        fire && word.sector_start |=> pos_reg == POS_W'(1))
        else $error("position not restarted by sector start");

    // Position never passes the idle point
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_W'(POS_IDLE))
        else $error("position beyond idle");

    // Without a processed word the sector state holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(pos_reg) && $stable(xor_reg))
        else $error("sector state changed without a word");

endmodule

@@ rtl/msh_out_stage.sv @@
// Result register of the sector header decoder.
// Depends on msh_pkg for the result word type.
module msh_out_stage (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          load,
    input  logic          load_valid,
    input  msh_pkg::out_t load_word,
    output logic          free,
    output logic          result_valid,
    input  logic          result_stall,
    output msh_pkg::out_t result
);
    import msh_pkg::*;

    logic valid_reg;
    logic valid_next;
    out_t word_reg;

    // Room for a new result when empty or being taken this cycle
    assign free = !valid_reg || !result_stall;

    always_comb
    begin
        if (load)
            valid_next = load_valid;
        else if (!result_stall)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load && load_valid)
            word_reg <= load_word;
    end

    assign result_valid = valid_reg;
    assign result       = word_reg;

endmodule

@@ rtl/mfm_sector_header_decoder_core.sv @@
// Top level of the MFM sector header decoder.
// An accepted word passes through the input register, then the result register.
// Throughput: one word per cycle while the result is not stalled, set by the input and result registers.
// The position / checksum update for each word is computed combinationally and registered.
// Reset: idle until a sector start, odd half and checksum cleared, no result held.
// Depends on msh_pkg, msh_in_stage, msh_decode and msh_out_stage.
module mfm_sector_header_decoder_core #(
    parameter int unsigned LABEL_WORDS = msh_pkg::LABEL_WORDS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          item_valid,
    output logic          item_stall,
    input  msh_pkg::in_t  item,
    output logic          result_valid,
    input  logic          result_stall,
    output msh_pkg::out_t result
);
    import msh_pkg::*;

    logic held_valid;
    in_t  held;
    logic advance;
    logic out_free;
    logic res_valid;
    out_t res;

    // Held word moves on when the result register has room
    assign advance = held_valid && out_free;

    msh_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .advance    (advance),
        .held_valid (held_valid),
        .held       (held)
    );

    msh_decode #(
        .LABEL_WORDS (LABEL_WORDS)
    ) u_dec (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (advance),
        .word      (held),
        .res_valid (res_valid),
        .res       (res)
    );

    msh_out_stage u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (advance),
        .load_valid   (res_valid),
        .load_word    (res),
        .free         (out_free),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // Input stalls only when a result is blocked downstream
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> result_valid && result_stall)
        else $error("input stalled without a blocked result");

endmodule

@@ tb/sv/mfm_sector_header_decoder_core_tb.sv @@
// Self-checking testbench for mfm_sector_header_decoder_core: it drives raw MFM sector words and
// checks every decoded result against its own model of the sector layout.
// Depends on msh_pkg and the decoder RTL.
`timescale 1ns / 100ps

module mfm_sector_header_decoder_core_tb;

    import msh_pkg::*;

    // Sector layout for the default label count
    localparam int LW           = LABEL_WORDS_DEF;
    localparam int POS_LBL_ODD  = 2;
    localparam int POS_LBL_EVEN = 2 + LW;
    localparam int POS_HDR      = 2 + 2 * LW;
    localparam int POS_DATA     = POS_HDR + 2;
    localparam int POS_IDLE     = POS_DATA + 2;
    localparam int POS_W        = $clog2(POS_IDLE + 1);
    localparam int DRAIN_CYCLES = 6;

    typedef enum int {
        FILL_RANDOM,
        FILL_ONES,
        FILL_ZEROS
    } fill_t;

    logic   clk          = 1'b0;
    logic   rst_n        = 1'b0;
    logic   item_valid   = 1'b0;
    logic   item_stall;
    in_t    item         = '0;
    logic   result_valid;
    logic   result_stall = 1'b0;
    out_t   result;

    // Idling controls, in percent
    int     sender_gap_pct    = 0;
    int     result_stall_pct  = 0;

    // Decoder model state, matches the block after reset
    logic [POS_W-1:0] sector_pos = POS_W'(POS_IDLE);
    logic [31:0]      odd_latch  = '0;
    logic [31:0]      odd_label_mem [LW];
    logic [31:0]      running_xor = '0;

    out_t   pending_results [$];
    int     fail_count      = 0;
    int     words_consumed  = 0;
    int     results_checked = 0;
    int     sectors_sent    = 0;
    int     hdr_ok_seen     = 0;
    int     hdr_bad_seen    = 0;

    mfm_sector_header_decoder_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always #5 clk = ~clk;

    // Hard limit on the run
    initial
    begin
        #2_000_000;
        $error("timeout: %0d results still outstanding", pending_results.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Random result stall, changed on the falling edge
    always @(negedge clk)
    begin
        result_stall <= ($urandom_range(99) < result_stall_pct);
    end

    // Odd halves supply the upper bit of each pair
    function automatic logic [31:0] join_halves(input logic [31:0] odd, input logic [31:0] even);
        join_halves = ((odd & MFM_MASK) << 1) | (even & MFM_MASK);
    endfunction

    // Advance the sector model by one word; returns 1 if a result is due
    function automatic bit decode_header_word(input in_t w, output out_t r);
        logic [POS_W-1:0] p;
        logic [31:0]      m;
        int unsigned      idx;
        r = '0;
        if (w.sector_start)
        begin
            sector_pos  = '0;
            running_xor = '0;
        end
        p = sector_pos;
        if (p >= POS_IDLE)
        begin
            sector_pos = POS_W'(POS_IDLE);
            return 1'b0;
        end
        words_consumed++;
        sector_pos = p + 1'b1;
        if (p < POS_HDR)
            running_xor ^= w.raw_word;

        // Odd halves are only held
        if (p == 0 || p == POS_HDR || p == POS_DATA)
        begin
            odd_latch = w.raw_word;
            return 1'b0;
        end
        if (p >= POS_LBL_ODD && p < POS_LBL_EVEN)
        begin
            odd_label_mem[p - POS_LBL_ODD] = w.raw_word;
            return 1'b0;
        end

        // Even halves give a result
        if (p == 1)
        begin
            m                = join_halves(odd_latch, w.raw_word);
            r.kind           = KIND_INFO;
            r.merged_value   = m;
            r.format_byte    = m[31:24];
            r.cylinder       = m[23:17];
            r.head           = m[16];
            r.sector_id      = m[15:8];
            r.sectors_to_gap = m[7:0];
        end
        else if (p < POS_HDR)
        begin
            idx            = p - POS_LBL_EVEN;
            r.kind         = KIND_LABEL;
            r.merged_value = join_halves(odd_label_mem[idx], w.raw_word);
            r.label_index  = idx[1:0];
        end
        else if (p == POS_HDR + 1)
        begin
            m              = join_halves(odd_latch, w.raw_word);
            r.kind         = KIND_HDR_CSUM;
            r.merged_value = m;
            r.header_ok    = ((running_xor & MFM_MASK) == m);
        end
        else
        begin
            r.kind         = KIND_DATA_CSUM;
            r.merged_value = join_halves(odd_latch, w.raw_word);
        end
        return 1'b1;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] exp_v,
                                        input logic [31:0] act_v);
        if (act_v !== exp_v)
        begin
            $error("%s: expected %h, got %h", name, exp_v, act_v);
            fail_count++;
        end
    endfunction

    // Result checking and prediction of accepted words, both on the rising edge
    always @(posedge clk)
    begin : monitor
        out_t exp_r;
        out_t pred;
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("unexpected result: kind %0d value %h", result.kind,
                           result.merged_value);
                    fail_count++;
                end
                else
                begin
                    exp_r = pending_results.pop_front();
                    check_field("kind", 32'(exp_r.kind), 32'(result.kind));
                    check_field("merged_value", exp_r.merged_value, result.merged_value);
                    check_field("format_byte", 32'(exp_r.format_byte),
                                32'(result.format_byte));
                    check_field("cylinder", 32'(exp_r.cylinder), 32'(result.cylinder));
                    check_field("head", 32'(exp_r.head), 32'(result.head));
                    check_field("sector_id", 32'(exp_r.sector_id), 32'(result.sector_id));
                    check_field("sectors_to_gap", 32'(exp_r.sectors_to_gap),
                                32'(result.sectors_to_gap));
                    check_field("label_index", 32'(exp_r.label_index),
                                32'(result.label_index));
                    check_field("header_ok", 32'(exp_r.header_ok), 32'(result.header_ok));
                    results_checked++;
                    if (exp_r.kind == KIND_HDR_CSUM)
                    begin
                        if (exp_r.header_ok)
                            hdr_ok_seen++;
                        else
                            hdr_bad_seen++;
                    end
                end
            end
            if (item_valid && !item_stall)
            begin
                if (decode_header_word(item, pred))
                    pending_results.push_back(pred);
            end
        end
    end

    // Send one word; called and returns at a falling edge
    task automatic send_word(input logic [31:0] w, input logic start);
        while ($urandom_range(99) < sender_gap_pct)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item.raw_word     <= w;
        item.sector_start <= start;
        item_valid        <= 1'b1;
        do
            @(posedge clk);
        while (item_stall);
        @(negedge clk);
    endtask

    // Hold off the sender until every outstanding result is back
    task automatic wait_for_drain();
        item_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    function automatic logic [31:0] fill_word(input fill_t fill);
        unique case (fill)
            FILL_ONES:  fill_word = '1;
            FILL_ZEROS: fill_word = '0;
            default:    fill_word = $urandom;
        endcase
    endfunction

    // One sector, possibly cut short; the header checksum is built to match or to miss by one bit
    task automatic send_sector(input fill_t fill, input bit hdr_good, input int n_words);
        logic [31:0] raw [POS_IDLE];
        logic [31:0] csum;
        logic [31:0] target;
        int          i;
        csum = '0;
        for (i = 0; i < POS_HDR; i++)
        begin
            raw[i] = fill_word(fill);
            csum  ^= raw[i];
        end
        target = csum & MFM_MASK;
        if (!hdr_good)
            target ^= 32'h1 << $urandom_range(31);
        raw[POS_HDR]      = ((target >> 1) & MFM_MASK) | (fill_word(fill) & ~MFM_MASK);
        raw[POS_HDR + 1]  = (target & MFM_MASK) | (fill_word(fill) & ~MFM_MASK);
        raw[POS_DATA]     = fill_word(fill);
        raw[POS_DATA + 1] = fill_word(fill);
        for (i = 0; i < n_words; i++)
            send_word(raw[i], i == 0);
        if (n_words == POS_IDLE)
            sectors_sent++;
    endtask

    // Unmarked words straight after reset are ignored
    task automatic test_idle_words();
        send_word('1, 1'b0);
        send_word('0, 1'b0);
    endtask

    // Zero-filled sector abandoned after its first labels
    task automatic test_restart_mid_sector();
        send_sector(FILL_ZEROS, 1'b1, 5);
    endtask

    // All-ones sector with a bad header checksum, then words past its end
    task automatic test_extreme_sector();
        send_sector(FILL_ONES, 1'b0, POS_IDLE);
        send_word('1, 1'b0);
        send_word('0, 1'b0);
    endtask

    // Mostly whole sectors, some cut short, some noise and trailing words
    task automatic test_random_traffic(input int n_words, input int gap_pct, input int stall_pct);
        int start_count;
        int sel;
        sender_gap_pct   = gap_pct;
        result_stall_pct = stall_pct;
        start_count      = words_consumed;
        while (words_consumed - start_count < n_words)
        begin
            sel = $urandom_range(99);
            if (sel < 70)
                send_sector(FILL_RANDOM, $urandom_range(9) < 7, POS_IDLE);
            else if (sel < 80)
                send_sector(FILL_RANDOM, 1'b1, $urandom_range(POS_IDLE - 1, 1));
            else if (sel < 90)
                repeat ($urandom_range(4, 1)) send_word($urandom, $urandom_range(7) == 0);
            else
            begin
                send_sector(FILL_RANDOM, 1'b1, POS_IDLE);
                repeat ($urandom_range(3, 1)) send_word($urandom, 1'b0);
            end
            if ($urandom_range(49) == 0)
                wait_for_drain();
        end
        wait_for_drain();
    endtask

    initial
    begin
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_idle_words();
        test_restart_mid_sector();
        test_extreme_sector();
        wait_for_drain();

        test_random_traffic(335, 0, 0);
        test_random_traffic(335, 64, 0);
        test_random_traffic(335, 0, 64);
        test_random_traffic(335, 32, 32);

        $display("Decoded %0d words in %0d whole sectors and checked %0d results",
                 words_consumed, sectors_sent, results_checked);
        $display("Header checksums seen: %0d matching, %0d mismatching",
                 hdr_ok_seen, hdr_bad_seen);
        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/msh_pkg.sv
rtl/msh_in_stage.sv
rtl/msh_decode.sv
rtl/msh_out_stage.sv
rtl/mfm_sector_header_decoder_core.sv
tb/sv/mfm_sector_header_decoder_core_tb.sv
